>>> rtl/bedm_pkg.sv
// Shared constants, types and codes for the bounded edit distance matcher.
// No dependencies; every other file but bedm_ram uses this package.
`timescale 1ns / 1ps
package bedm_pkg;

  // Sizing
  localparam int PatternMax = 32;
  localparam int EditMax    = 7;
  localparam int RowDepth   = PatternMax + 1;
  localparam int RowAw      = $clog2(RowDepth);
  localparam int IssW       = $clog2(RowDepth + 1);
  localparam int PatAw      = $clog2(PatternMax);
  localparam int DistW      = $clog2(EditMax + 3);

  // Field widths
  localparam int CmdW = 2;
  localparam int SymW = 8;
  localparam int PosW = 5;
  localparam int LimW = 3;
  localparam int LenW = 6;
  localparam int EndW = 4;

  // Register port
  localparam int ApbAw = 3;
  localparam int ApbDw = 32;
  localparam logic RegEditLimit     = 1'b0;
  localparam logic RegPatternLength = 1'b1;
  localparam logic [LimW-1:0] EditLimitRst  = LimW'(1);
  localparam logic [LenW-1:0] PatternLenRst = LenW'(0);

  // Saturation value of the row right after reset
  localparam int InitSatRst = ((int'(EditLimitRst) > EditMax) ? EditMax
                                                               : int'(EditLimitRst)) + 1;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD = 2'd0,
    CMD_FEED = 2'd1,
    CMD_END  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [LimW-1:0] edit_limit;
    logic [LenW-1:0] pattern_length;
  } cfg_t;

endpackage

>>> rtl/bedm_if.sv
// Valid/ready channel interfaces for query beats in and status beats out.
// Depends on bedm_pkg for field widths.
`timescale 1ns / 1ps
interface bedm_in_if;
  import bedm_pkg::*;

  logic            valid;
  logic            ready;
  logic [CmdW-1:0] cmd;
  logic [SymW-1:0] symbol;
  logic [PosW-1:0] load_position;

  modport source (output valid, cmd, symbol, load_position, input ready);
  modport sink   (input valid, cmd, symbol, load_position, output ready);
endinterface

interface bedm_out_if;
  import bedm_pkg::*;

  logic            valid;
  logic            ready;
  logic            within_limit;
  logic            reachable;
  logic [EndW-1:0] end_distance;

  modport source (output valid, within_limit, reachable, end_distance, input ready);
  modport sink   (input valid, within_limit, reachable, end_distance, output ready);
endinterface

>>> rtl/bedm_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bedm_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  localparam int Aw = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bedm_regs.sv
// APB-style configuration registers: edit limit and pattern length.
// Depends on bedm_pkg for widths, reset values and register indexes.
`timescale 1ns / 1ps
module bedm_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [bedm_pkg::ApbAw-1:0]  paddr_i,
  input  logic [bedm_pkg::ApbDw-1:0]  pwdata_i,
  output logic [bedm_pkg::ApbDw-1:0]  prdata_o,
  output logic                        pready_o,
  output bedm_pkg::cfg_t              cfg_o
);
  import bedm_pkg::*;

  cfg_t cfg_q;
  logic wr_en;
  logic reg_idx;

  assign reg_idx = paddr_i[2];
  assign wr_en   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.edit_limit     <= EditLimitRst;
      cfg_q.pattern_length <= PatternLenRst;
    end else if (wr_en) begin
      case (reg_idx)
        RegEditLimit:     cfg_q.edit_limit     <= pwdata_i[LimW-1:0];
        RegPatternLength: cfg_q.pattern_length <= pwdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegEditLimit:     prdata_o = ApbDw'(cfg_q.edit_limit);
      RegPatternLength: prdata_o = ApbDw'(cfg_q.pattern_length);
      default:          prdata_o = '0;
    endcase
  end

  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

endmodule

>>> rtl/bounded_edit_distance_matcher_unit.sv
// Top level of the bounded edit distance matcher (Levenshtein automaton row).
// Depends on bedm_pkg, bedm_if, bedm_ram and bedm_regs.
`timescale 1ns / 1ps
// Usage: load the pattern with load beats (one byte per beat at load_position),
// set pattern_length and edit_limit over the register port while idle, then
// stream query characters with feed beats and close each query with an end
// beat, which also restores the distance row to 0, 1, ... clamped at
// edit_limit+1. Every beat returns exactly one status beat; load, end and the
// unused command report the row as it stood before the beat, a feed beat
// reports the row after its update. No new beat is accepted until the last
// one has passed its status on; each beat walks entries 0 to L, with L the
// pattern length in use (0 to 32): the distance row lives in a single RAM with
// one read and one write port, and the recurrence walks it one entry per cycle.
// The row needs no clearing pass after reset or an end beat: per-entry valid
// flops are cleared at once and an unwritten entry reads as its initial value.
module bounded_edit_distance_matcher_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bedm_in_if.sink                     in_if,
  bedm_out_if.source                  out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bedm_pkg::ApbAw-1:0]  paddr,
  input  logic [bedm_pkg::ApbDw-1:0]  pwdata,
  output logic [bedm_pkg::ApbDw-1:0]  prdata,
  output logic                        pready
);
  import bedm_pkg::*;

  // Configuration
  cfg_t             cfg;
  logic [DistW-1:0] lim;
  logic [DistW-1:0] sat;
  logic [RowAw-1:0] len;

  bedm_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  assign lim = (int'(cfg.edit_limit) > EditMax) ? DistW'(EditMax) : DistW'(cfg.edit_limit);
  assign sat = lim + DistW'(1);
  assign len = (int'(cfg.pattern_length) > PatternMax) ? RowAw'(PatternMax)
                                                        : RowAw'(cfg.pattern_length);

  // Control
  state_e state_q, state_d;
  logic   in_fire;
  logic   issue;
  logic   last_data;
  logic   fire_out;

  // Beat context
  cmd_e            cmd_q;
  logic [SymW-1:0] sym_q;

  // Sweep pipeline: issue stage and data stage
  logic [IssW-1:0]  iss_q;
  logic             dat_vld_q;
  logic [RowAw-1:0] dat_idx_q;
  logic [DistW-1:0] prev_old_q;
  logic [DistW-1:0] prev_new_q;
  logic             any_q;
  logic [DistW-1:0] end_q;

  // Row initial value bookkeeping
  logic [RowDepth-1:0] valid_q;
  logic [DistW-1:0]    init_sat_q;

  // Output register
  logic            out_vld_q;
  logic            within_limit_q;
  logic            reachable_q;
  logic [EndW-1:0] end_dist_q;

  // Memories
  logic [DistW-1:0] row_rdata;
  logic [SymW-1:0]  pat_rdata;
  logic             row_we;
  logic             pat_we;
  logic [RowAw-1:0] iss_addr;
  logic [IssW-1:0]  iss_prev;

  // Data stage values
  logic [DistW-1:0] init_val;
  logic [DistW-1:0] old_val;
  logic [DistW-1:0] feed_val;
  logic [DistW-1:0] rep_val;
  logic [DistW-1:0] end_val;

  assign iss_addr = iss_q[RowAw-1:0];
  assign iss_prev = iss_q - IssW'(1);
  assign pat_we   = in_fire && (cmd_e'(in_if.cmd) == CMD_LOAD)
                    && (int'(in_if.load_position) < PatternMax);
  assign row_we   = dat_vld_q && (cmd_q == CMD_FEED);

  bedm_ram #(.Width(DistW), .Depth(RowDepth)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (dat_idx_q),
    .wdata_i (feed_val),
    .raddr_i (iss_addr),
    .rdata_o (row_rdata)
  );

  bedm_ram #(.Width(SymW), .Depth(PatternMax)) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (PatAw'(in_if.load_position)),
    .wdata_i (in_if.symbol),
    .raddr_i (iss_prev[PatAw-1:0]),
    .rdata_o (pat_rdata)
  );

  // FSM: accept in idle, walk entries 0..L, then hand the status to the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_if.ready = 1'b0;
    issue       = 1'b0;
    fire_out    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        issue = (iss_q <= IssW'(len));
        if (last_data) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_vld_q || out_if.ready) begin
          fire_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_fire   = in_if.valid && in_if.ready;
  assign last_data = dat_vld_q && (dat_idx_q == len);

  // Data stage: one Levenshtein cell per cycle.
  always_comb begin
    logic [DistW-1:0] diag;
    logic [DistW-1:0] up;
    logic [DistW-1:0] left;
    logic [DistW-1:0] best;
    diag = prev_old_q + DistW'(pat_rdata != sym_q);
    up   = old_val + DistW'(1);
    left = prev_new_q + DistW'(1);
    best = diag;
    if (up < best) begin
      best = up;
    end
    if (left < best) begin
      best = left;
    end
    if (dat_idx_q == '0) begin
      best = up;
    end
    feed_val = (best > sat) ? sat : best;
  end

  // Entries never written since the last row reset read as min(i, saturation then).
  assign init_val = (int'(dat_idx_q) < int'(init_sat_q)) ? DistW'(dat_idx_q) : init_sat_q;
  assign old_val  = valid_q[dat_idx_q] ? row_rdata : init_val;
  assign rep_val  = (cmd_q == CMD_FEED) ? feed_val : old_val;
  assign end_val  = (rep_val > sat) ? sat : rep_val;

  // Control registers of the sweep and the output side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q      <= '0;
      dat_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
      valid_q    <= '0;
      init_sat_q <= DistW'(InitSatRst);
    end else begin
      dat_vld_q <= issue;
      if (in_fire) begin
        iss_q <= '0;
      end else if (issue) begin
        iss_q <= iss_q + IssW'(1);
      end
      if (row_we) begin
        valid_q[dat_idx_q] <= 1'b1;
      end
      if (fire_out) begin
        out_vld_q <= 1'b1;
        if (cmd_q == CMD_END) begin
          valid_q    <= '0;
          init_sat_q <= sat;
        end
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cmd_e'(in_if.cmd);
      sym_q <= in_if.symbol;
      any_q <= 1'b0;
    end
    dat_idx_q <= iss_addr;
    if (dat_vld_q) begin
      prev_old_q <= old_val;
      prev_new_q <= feed_val;
      if (rep_val <= lim) begin
        any_q <= 1'b1;
      end
      if (last_data) begin
        end_q <= end_val;
      end
    end
    if (fire_out) begin
      within_limit_q <= (end_q <= lim);
      reachable_q    <= any_q;
      end_dist_q     <= EndW'(end_q);
    end
  end

  assign out_if.valid        = out_vld_q;
  assign out_if.within_limit = within_limit_q;
  assign out_if.reachable    = reachable_q;
  assign out_if.end_distance = end_dist_q;

endmodule

>>> rtl/bedm_checker.sv
// Port-level assertions for the matcher top level, attached with bind.
// Depends on bedm_pkg and bounded_edit_distance_matcher_unit.
`timescale 1ns / 1ps
module bedm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       within_limit_i,
  input logic                       reachable_i,
  input logic [bedm_pkg::EndW-1:0]  end_distance_i
);
  import bedm_pkg::*;

  // Ready goes low once a beat is accepted, while the row is walked.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready stayed high after an accepted beat");

  // The end entry is itself a row entry.
  a_match_implies_reach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && within_limit_i |-> reachable_i)
    else $error("within_limit without reachable");

  a_end_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> end_distance_i <= EndW'(EditMax + 1))
    else $error("end_distance above saturation");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable({within_limit_i, reachable_i, end_distance_i}))
    else $error("stalled status beat changed");

endmodule

bind bounded_edit_distance_matcher_unit bedm_checker u_bedm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_if.valid),
  .in_ready_i     (in_if.ready),
  .out_valid_i    (out_if.valid),
  .out_ready_i    (out_if.ready),
  .within_limit_i (out_if.within_limit),
  .reachable_i    (out_if.reachable),
  .end_distance_i (out_if.end_distance)
);

>>> test/tb.sv
// Self-checking bench for bounded_edit_distance_matcher_unit: directed beats, then random queries.
// Depends on bedm_pkg, the bedm_in_if / bedm_out_if channel interfaces and the matcher top level.
`timescale 1ns / 1ps
module tb;
  import bedm_pkg::*;

  typedef struct packed {
    logic            within_limit;
    logic            reachable;
    logic [EndW-1:0] end_distance;
  } status_t;

  // Tracks pattern, distance row and registers; predicts one status beat per input beat
  // and holds those predictions until the matching output beat shows up.
  class edit_status_board;
    logic [SymW-1:0]  pattern [PatternMax];
    logic [DistW-1:0] row [RowDepth];
    logic [LimW-1:0]  edit_limit;
    logic [LenW-1:0]  pattern_length;
    status_t          expected_status [$];
    int               mismatches;

    function new();
      foreach (pattern[i]) pattern[i] = '0;
      edit_limit     = EditLimitRst;
      pattern_length = PatternLenRst;
      mismatches     = 0;
      reset_row();
    endfunction

    function int limit_in_use();
      return (int'(edit_limit) > EditMax) ? EditMax : int'(edit_limit);
    endfunction

    function int len_in_use();
      return (int'(pattern_length) > PatternMax) ? PatternMax : int'(pattern_length);
    endfunction

    function void reset_row();
      int sat;
      sat = limit_in_use() + 1;
      foreach (row[i]) row[i] = DistW'((i < sat) ? i : sat);
    endfunction

    // One step of the Levenshtein recurrence, saturating at limit+1
    function void step_row(logic [SymW-1:0] ch);
      int sat, len, prev_old, old, v;
      sat      = limit_in_use() + 1;
      len      = len_in_use();
      prev_old = int'(row[0]);
      v        = prev_old + 1;
      row[0]   = DistW'((v > sat) ? sat : v);
      for (int i = 1; i <= len; i++) begin
        old = int'(row[i]);
        v   = prev_old + ((pattern[i-1] == ch) ? 0 : 1);
        if (old + 1 < v) v = old + 1;
        if (int'(row[i-1]) + 1 < v) v = int'(row[i-1]) + 1;
        if (v > sat) v = sat;
        prev_old = old;
        row[i]   = DistW'(v);
      end
    endfunction

    function status_t status_now();
      status_t s;
      int lim, endv, len;
      bit any;
      lim  = limit_in_use();
      len  = len_in_use();
      endv = int'(row[len]);
      if (endv > lim + 1) endv = lim + 1;
      any = 1'b0;
      for (int i = 0; i <= len; i++) if (int'(row[i]) <= lim) any = 1'b1;
      s.within_limit = (endv <= lim);
      s.reachable    = any;
      s.end_distance = EndW'(endv);
      return s;
    endfunction

    function void queue_status(status_t s);
      expected_status = {expected_status, s};
    endfunction

    function void write_register(logic idx, logic [ApbDw-1:0] value);
      case (idx)
        RegEditLimit:     edit_limit     = value[LimW-1:0];
        RegPatternLength: pattern_length = value[LenW-1:0];
        default: ;
      endcase
    endfunction

    function void absorb_beat(cmd_e c, logic [SymW-1:0] sym, logic [PosW-1:0] pos);
      case (c)
        CMD_LOAD: begin
          queue_status(status_now());
          if (int'(pos) < PatternMax) pattern[pos] = sym;
        end
        CMD_FEED: begin
          step_row(sym);
          queue_status(status_now());
        end
        CMD_END: begin
          queue_status(status_now());
          reset_row();
        end
        default: queue_status(status_now());
      endcase
    endfunction

    function void check_status(status_t got);
      status_t want;
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: status beat with nothing expected: match=%0b can=%0b dist=%0d",
                   $time, got.within_limit, got.reachable, got.end_distance);
        return;
      end
      want = expected_status.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: status mismatch: want match=%0b can=%0b dist=%0d, got %0b %0b %0d",
                   $time, want.within_limit, want.reachable, want.end_distance,
                   got.within_limit, got.reachable, got.end_distance);
      end
    endfunction
  endclass

  localparam int CycleLimit = 500000;
  localparam int HoldCycles = 300;   // long receiver hold-off, fills the block up
  localparam int DrainWait  = 40;    // outlasts a whole beat with L at most 32

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel, penable, pwrite;
  logic [ApbAw-1:0] paddr;
  logic [ApbDw-1:0] pwdata;
  logic [ApbDw-1:0] prdata;
  logic             pready;

  bedm_in_if  in_if ();
  bedm_out_if out_if ();

  bounded_edit_distance_matcher_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk_i = ~clk_i;

  edit_status_board board = new();

  bit              calm;          // no idling on either side while set
  bit              hold_pending;  // main asks, receiver runs the long hold-off
  int              beats_sent;
  int              cycle_count;
  bit [PatternMax-1:0] loaded;    // pattern positions written so far

  // Input side: random gaps, then hold valid until the beat is taken.
  // ready is sampled at the edge, before any NBA of that step lands.
  task automatic send_beat(cmd_e c, logic [SymW-1:0] sym, logic [PosW-1:0] pos);
    while (!calm && $urandom_range(99) < 37) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.cmd           <= c;
    in_if.symbol        <= sym;
    in_if.load_position <= pos;
    do @(posedge clk_i); while (!in_if.ready);
    board.absorb_beat(c, sym, pos);
    if (c == CMD_LOAD) loaded[pos] = 1'b1;
    beats_sent++;
  endtask

  // Setup cycle, then access cycle; the register takes the value at the access edge.
  // psel drops before return so back-to-back writes never collide.
  task automatic reg_write(logic idx, logic [ApbDw-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.write_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid, let every expected beat come back, then give the block time to settle
  task automatic settle();
    in_if.valid <= 1'b0;
    while (board.expected_status.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Feeds compare against positions below the length in use: write any gaps first
  task automatic fill_pattern();
    for (int p = 0; p < board.len_in_use(); p++)
      if (!loaded[p]) send_beat(CMD_LOAD, 8'($urandom), PosW'(p));
  endtask

  task automatic configure(int lim, int len);
    reg_write(RegEditLimit, ApbDw'(lim));
    reg_write(RegPatternLength, ApbDw'(len));
    fill_pattern();
  endtask

  // A query built as the pattern with a few random edits, mostly closed by an end beat
  task automatic send_query();
    int len, j, r, tail;
    len = board.len_in_use();
    j   = 0;
    while (j < len) begin
      r = $urandom_range(99);
      if (r < 70) begin
        send_beat(CMD_FEED, board.pattern[j], 5'($urandom));
        j++;
      end else if (r < 80) begin
        send_beat(CMD_FEED, 8'($urandom), 5'($urandom));  // insertion
      end else if (r < 90) begin
        j++;                                                // deletion
      end else begin
        send_beat(CMD_FEED, 8'($urandom), 5'($urandom));  // substitution
        j++;
      end
    end
    tail = $urandom_range(2);
    repeat (tail) send_beat(CMD_FEED, 8'($urandom), 5'($urandom));
    if ($urandom_range(9) != 0) send_beat(CMD_END, 8'($urandom), 5'($urandom));
  endtask

  // Stray beats: loads mid query, unused command, random chars, early ends
  task automatic send_noise();
    case ($urandom_range(3))
      0: send_beat(CMD_LOAD, 8'($urandom), 5'($urandom));
      1: send_beat(CMD_NOP, 8'($urandom), 5'($urandom));
      2: send_beat(CMD_FEED, 8'($urandom), 5'($urandom));
      default: send_beat(CMD_END, 8'($urandom), 5'($urandom));
    endcase
  endtask

  // Output side: check each taken beat, then pick ready for the next edge
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready)
        board.check_status({out_if.within_limit, out_if.reachable, out_if.end_distance});
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= 37);
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int lim, len, r, phase_end;
    rst_ni              <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_if.valid         <= 1'b0;
    in_if.cmd           <= CMD_NOP;
    in_if.symbol        <= '0;
    in_if.load_position <= '0;
    calm                = 1'b0;
    hold_pending        = 1'b0;
    beats_sent          = 0;
    loaded              = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, empty pattern: the row only grows at entry zero
    send_beat(CMD_NOP, 8'h00, 5'd0);
    send_beat(CMD_FEED, 8'h00, 5'd0);
    send_beat(CMD_FEED, 8'hFF, 5'd31);
    send_beat(CMD_END, 8'hFF, 5'd31);
    // Loads report the row as it stood before them; byte and position extremes
    send_beat(CMD_LOAD, 8'h00, 5'd0);
    send_beat(CMD_LOAD, 8'hFF, 5'd1);
    send_beat(CMD_LOAD, 8'h41, 5'd2);
    send_beat(CMD_LOAD, 8'hA5, 5'd31);
    settle();

    // Zero edits allowed: exact hit, then a miss
    configure(0, 3);
    send_beat(CMD_FEED, 8'h00, 5'd0);
    send_beat(CMD_FEED, 8'hFF, 5'd0);
    send_beat(CMD_FEED, 8'h41, 5'd0);
    send_beat(CMD_END, 8'h00, 5'd0);
    send_beat(CMD_FEED, 8'h41, 5'd0);
    send_beat(CMD_END, 8'h00, 5'd0);
    settle();

    // Widest limit, query left open across a register change
    configure(7, 3);
    send_beat(CMD_FEED, 8'h00, 5'd0);
    send_beat(CMD_FEED, 8'h00, 5'd0);
    settle();
    // Limit lowered mid query: stale entries above the new ceiling get clamped
    configure(1, 2);
    send_beat(CMD_FEED, 8'hFF, 5'd0);
    send_beat(CMD_NOP, 8'h12, 5'd7);
    send_beat(CMD_END, 8'h34, 5'd9);
    settle();

    // Random phases, each with its own register setting
    for (int ph = 0; ph < 14; ph++) begin
      lim = (ph == 0) ? 0 : (ph == 1) ? EditMax : $urandom_range(7);
      r   = $urandom_range(99);
      if (ph == 2)      len = PatternMax;
      else if (ph == 3) len = 63;                         // clamped to the store size
      else if (ph == 4) len = 0;
      else if (r < 70)  len = $urandom_range(1, 8);
      else if (r < 85)  len = $urandom_range(9, PatternMax);
      else              len = $urandom_range(PatternMax + 1, 63);
      configure(lim, len);
      calm = (ph == 5);                                   // one stretch with no idling
      if (ph == 6) hold_pending = 1'b1;                   // long back-pressure episode
      phase_end = beats_sent + 56;
      while (beats_sent < phase_end) begin
        if ($urandom_range(99) < 82) send_query();
        else send_noise();
      end
      settle();
      calm = 1'b0;
    end

    if (board.mismatches == 0 && board.expected_status.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
